// ===== design/tdccal_pkg.sv =====
// shared constants, codes and types of the tdc hit time calibrator
package tdccal_pkg;

   localparam int MAX_DETECTORS = 4;
   localparam int MAX_CHANNELS  = 4;
   localparam int MAX_BINS      = 1024;

   localparam int SIGNALS   = MAX_DETECTORS * MAX_CHANNELS;
   localparam int BIN_DEPTH = SIGNALS * MAX_BINS;
   localparam int SIG_W     = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;
   localparam int ADDR_W    = $clog2(BIN_DEPTH);
   localparam int ND_W      = $clog2(MAX_DETECTORS + 1);
   localparam int NC_W      = $clog2(MAX_CHANNELS + 1);
   localparam int NB_W      = $clog2(MAX_BINS + 1);

   // payload widths
   localparam int TYPE_W    = 2;
   localparam int DET_W     = 4;
   localparam int CH_W      = 4;
   localparam int FINE_W    = 10;
   localparam int COARSE_W  = 16;
   localparam int DITHER_W  = 10;
   localparam int LOAD_W    = 24;
   localparam int STATUS_W  = 3;
   localparam int TIME_W    = 32;
   localparam int BINVAL_W  = 16;

   // configuration registers
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int DET_REG_W   = 3;
   localparam int CH_REG_W    = 3;
   localparam int BIN_REG_W   = 11;

   localparam logic [CSR_IDX_W-1:0] REG_DETECTORS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BINS      = 2'd2;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_HIT         = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD_BIN    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_LOAD_OFFSET = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE        = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_DET   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_CH    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_BIN   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOAD_DONE = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // effective (clamped) configuration
   typedef struct packed {
      logic [ND_W-1:0] nd;
      logic [NC_W-1:0] nc;
      logic [NB_W-1:0] nb;
   } cfg_type;

   // classified item as it travels from the front to the back
   typedef struct packed {
      logic [TYPE_W-1:0]          req_type;
      logic [STATUS_W-1:0]        status;
      logic [DET_W-1:0]           detector;
      logic [CH_W-1:0]            channel;
      logic [COARSE_W-1:0]        coarse_time;
      logic signed [DITHER_W-1:0] dither;
      logic signed [LOAD_W-1:0]   load_value;
      logic [SIG_W-1:0]           sig;
      logic [ADDR_W-1:0]          addr;
      logic [ADDR_W-1:0]          nbr_addr;
      logic                       first_bin;
      logic                       last_bin;
   } work_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } queue_stat_type;

endpackage

// ===== design/tdccal_csr.sv =====
// configuration registers with apb-style access and clamped outputs
module tdccal_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tdccal_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tdccal_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tdccal_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output tdccal_pkg::cfg_type                  cfg
);
   import tdccal_pkg::*;

   logic [DET_REG_W-1:0] det_ff;
   logic [CH_REG_W-1:0]  ch_ff;
   logic [BIN_REG_W-1:0] bins_ff;
   logic                 wr_en;
   logic [CSR_IDX_W-1:0] idx;
   logic [15:0]          det_ext;
   logic [15:0]          ch_ext;
   logic [15:0]          bins_ext;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         det_ff  <= DET_REG_W'(1);
         ch_ff   <= CH_REG_W'(1);
         bins_ff <= BIN_REG_W'(1024);
      end else if (wr_en) begin
         unique case (idx)
            REG_DETECTORS: det_ff  <= csr_pwdata[DET_REG_W-1:0];
            REG_CHANNELS:  ch_ff   <= csr_pwdata[CH_REG_W-1:0];
            REG_BINS:      bins_ff <= csr_pwdata[BIN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_DETECTORS: csr_prdata = CSR_DATA_W'(det_ff);
         REG_CHANNELS:  csr_prdata = CSR_DATA_W'(ch_ff);
         REG_BINS:      csr_prdata = CSR_DATA_W'(bins_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign det_ext  = 16'(det_ff);
   assign ch_ext   = 16'(ch_ff);
   assign bins_ext = 16'(bins_ff);

   assign cfg.nd = ND_W'((det_ext > 16'(MAX_DETECTORS)) ? 16'(MAX_DETECTORS) : det_ext);
   assign cfg.nc = NC_W'((ch_ext > 16'(MAX_CHANNELS)) ? 16'(MAX_CHANNELS) : ch_ext);
   assign cfg.nb = NB_W'((bins_ext > 16'(MAX_BINS)) ? 16'(MAX_BINS) : bins_ext);

endmodule

// ===== design/tdccal_front.sv =====
// front end: accepts beats, checks ranges, forms signal index and table addresses
module tdccal_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tdccal_pkg::cfg_type                     cfg,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [tdccal_pkg::TYPE_W-1:0]           req_type,
   input  logic [tdccal_pkg::DET_W-1:0]            req_detector,
   input  logic [tdccal_pkg::CH_W-1:0]             req_channel,
   input  logic [tdccal_pkg::FINE_W-1:0]           req_fine_time,
   input  logic [tdccal_pkg::COARSE_W-1:0]         req_coarse_time,
   input  logic signed [tdccal_pkg::DITHER_W-1:0]  req_dither,
   input  logic signed [tdccal_pkg::LOAD_W-1:0]    req_load_value,
   input  logic                                    q_full,
   output logic                                    push,
   output tdccal_pkg::work_type                    push_data
);
   import tdccal_pkg::*;

   typedef struct packed {
      work_type    work;
      logic [15:0] fine;
      logic [15:0] fine_nbr;
   } stage_type;

   logic      v1_ff;
   logic      v2_ff;
   stage_type s1_ff;
   stage_type s1_in;
   work_type  s2_ff;
   work_type  s2_in;
   logic      ready1;
   logic      ready2;
   logic      accept;
   logic      bad_det;
   logic      bad_ch;
   logic      bad_bin;
   logic [15:0] sig_full;
   logic [31:0] base;

   assign ready2    = !v2_ff || !q_full;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;
   assign push      = v2_ff && !q_full;
   assign push_data = s2_ff;

   // classification
   assign bad_det = (req_detector == '0) || (16'(req_detector) > 16'(cfg.nd));
   assign bad_ch  = (req_channel == '0) || (16'(req_channel) > 16'(cfg.nc));
   assign bad_bin = (req_type != REQ_LOAD_OFFSET) && (16'(req_fine_time) >= 16'(cfg.nb));
   assign sig_full = 16'(16'(req_detector - DET_W'(1)) * 16'(cfg.nc))
                   + 16'(req_channel - CH_W'(1));

   always_comb begin
      s1_in = '0;
      priority if (bad_det) s1_in.work.status = ST_BAD_DET;
      else if (bad_ch)      s1_in.work.status = ST_BAD_CH;
      else if (bad_bin)     s1_in.work.status = ST_BAD_BIN;
      else if (req_type == REQ_HIT) s1_in.work.status = ST_OK;
      else                  s1_in.work.status = ST_LOAD_DONE;
      s1_in.work.req_type    = req_type;
      s1_in.work.detector    = req_detector;
      s1_in.work.channel     = req_channel;
      s1_in.work.coarse_time = req_coarse_time;
      s1_in.work.dither      = req_dither;
      s1_in.work.load_value  = req_load_value;
      s1_in.work.sig         = sig_full[SIG_W-1:0];
      s1_in.work.first_bin   = (req_fine_time == '0);
      s1_in.work.last_bin    = (16'(req_fine_time) + 16'd1) >= 16'(cfg.nb);
      s1_in.fine             = 16'(req_fine_time);
      // neighbor bin on the side the dither points to
      s1_in.fine_nbr         = req_dither[DITHER_W-1] ? 16'(req_fine_time) - 16'd1
                                                      : 16'(req_fine_time) + 16'd1;
   end

   // address stage
   assign base = 32'(s1_ff.work.sig) * 32'(cfg.nb);

   always_comb begin
      s2_in          = s1_ff.work;
      s2_in.addr     = ADDR_W'(base + 32'(s1_ff.fine));
      s2_in.nbr_addr = ADDR_W'(base + 32'(s1_ff.fine_nbr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= accept && (req_type != REQ_NONE);
         if (ready2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= s1_in;
      if (ready2 && v1_ff) s2_ff <= s2_in;
   end

endmodule

// ===== design/tdccal_queue.sv =====
// short queue between front and back end
module tdccal_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tdccal_pkg::work_type        push_data,
   input  logic                        pop,
   output logic                        q_valid,
   output tdccal_pkg::work_type        head,
   output tdccal_pkg::queue_stat_type  stat
);
   import tdccal_pkg::*;

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff;
   logic [QPTR_W-1:0] rp_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic [QCNT_W-1:0] cnt_in;

   assign q_valid    = (cnt_ff != '0);
   assign head       = entry_ff[rp_ff];
   assign stat.count = cnt_ff;
   assign stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + QCNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= (wp_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + QPTR_W'(1);
         if (pop)  rp_ff <= (rp_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + QPTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wp_ff] <= push_data;
   end

endmodule

// ===== design/tdccal_back.sv =====
// back end: calibration tables, fine and coarse arithmetic, result register
module tdccal_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   input  tdccal_pkg::work_type                    head,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [tdccal_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tdccal_pkg::DET_W-1:0]            rsp_hit_detector,
   output logic [tdccal_pkg::CH_W-1:0]             rsp_hit_channel,
   output logic signed [tdccal_pkg::TIME_W-1:0]    rsp_time_value,
   output logic [tdccal_pkg::COARSE_W-1:0]         rsp_clock_echo
);
   import tdccal_pkg::*;

   logic [BINVAL_W-1:0]    bin_mem [BIN_DEPTH];
   logic signed [LOAD_W-1:0] off_mem [SIGNALS];

   logic                   v1_ff;
   logic                   v2_ff;
   logic                   vo_ff;
   work_type               w1_ff;
   work_type               w2_ff;
   logic [BINVAL_W-1:0]    par_ff;
   logic [BINVAL_W-1:0]    nbr_ff;
   logic signed [LOAD_W-1:0] off_ff;
   logic signed [28:0]     finev_ff;
   logic signed [28:0]     finev_in;
   logic signed [31:0]     c5_ff;
   logic signed [31:0]     c5_in;

   logic                   ready_o;
   logic                   ready2;
   logic                   ready1;
   logic                   head_hit;
   logic                   head_ok;
   logic                   neg;
   logic signed [17:0]     par_s;
   logic signed [17:0]     nbr_sel;
   logic signed [17:0]     diff;
   logic signed [27:0]     mult;
   logic signed [27:0]     xdiff;
   logic signed [43:0]     total;
   logic signed [TIME_W-1:0] tval;

   assign ready_o = !vo_ff || !rsp_stall;
   assign ready2  = !v2_ff || ready_o;
   assign ready1  = !v1_ff || ready2;
   assign pop     = q_valid && ready1;

   assign head_ok  = (head.status == ST_OK) || (head.status == ST_LOAD_DONE);
   assign head_hit = (head.status == ST_OK);

   // table writes and reads, one item per beat popped from the queue
   always_ff @(posedge clock) begin
      if (pop && head_ok) begin
         if (head.req_type == REQ_LOAD_BIN)    bin_mem[head.addr] <= head.load_value[BINVAL_W-1:0];
         if (head.req_type == REQ_LOAD_OFFSET) off_mem[head.sig]  <= head.load_value;
      end
      if (pop && head_hit) begin
         par_ff <= bin_mem[head.addr];
         nbr_ff <= bin_mem[head.nbr_addr];
         off_ff <= off_mem[head.sig];
      end
   end

   // fine interpolation and coarse scaling
   assign neg   = w1_ff.dither[DITHER_W-1];
   assign par_s = $signed(18'(par_ff));

   always_comb begin
      priority if (neg && w1_ff.first_bin) nbr_sel = '0;
      else if (!neg && w1_ff.last_bin)     nbr_sel = par_s;
      else                                 nbr_sel = $signed(18'(nbr_ff));
   end

   assign diff     = neg ? (par_s - nbr_sel) : (nbr_sel - par_s);
   assign mult     = 28'(w1_ff.dither) * 28'(diff);
   assign finev_in = $signed(29'({par_ff, 10'b0})) + 29'(mult);
   assign xdiff    = $signed(28'({w1_ff.coarse_time, 10'b0})) - 28'(off_ff);
   // times five as shift and add
   assign c5_in    = (32'(xdiff) <<< 2) + 32'(xdiff);

   // coarse minus fine, floor of the division by 1024
   assign total = (44'(c5_ff) <<< 10) - 44'(finev_ff);
   assign tval  = TIME_W'(total >>> 10);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ready1)  v1_ff <= pop;
         if (ready2)  v2_ff <= v1_ff;
         if (ready_o) vo_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) w1_ff <= head;
      if (ready2 && v1_ff) begin
         w2_ff    <= w1_ff;
         finev_ff <= finev_in;
         c5_ff    <= c5_in;
      end
      if (ready_o && v2_ff) begin
         rsp_status       <= w2_ff.status;
         rsp_hit_detector <= w2_ff.detector;
         rsp_hit_channel  <= w2_ff.channel;
         rsp_clock_echo   <= w2_ff.coarse_time;
         rsp_time_value   <= (w2_ff.status == ST_OK) ? tval : '0;
      end
   end

   assign rsp_valid = vo_ff;

endmodule

// ===== design/tdccal_top.sv =====
// top level of the tdc hit time calibrator
module tdc_hit_time_calibrator_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [tdccal_pkg::TYPE_W-1:0]           req_type,
   input  logic [tdccal_pkg::DET_W-1:0]            req_detector,
   input  logic [tdccal_pkg::CH_W-1:0]             req_channel,
   input  logic [tdccal_pkg::FINE_W-1:0]           req_fine_time,
   input  logic [tdccal_pkg::COARSE_W-1:0]         req_coarse_time,
   input  logic signed [tdccal_pkg::DITHER_W-1:0]  req_dither,
   input  logic signed [tdccal_pkg::LOAD_W-1:0]    req_load_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [tdccal_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tdccal_pkg::DET_W-1:0]            rsp_hit_detector,
   output logic [tdccal_pkg::CH_W-1:0]             rsp_hit_channel,
   output logic signed [tdccal_pkg::TIME_W-1:0]    rsp_time_value,
   output logic [tdccal_pkg::COARSE_W-1:0]         rsp_clock_echo,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [tdccal_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tdccal_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tdccal_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                    csr_pready
);
   // Calibrates one beat per clock while no stall holds the flow: hits, bin loads
   // and offset loads all run at that rate. A beat passes the front end (range
   // checks and signal index, then the table address multiply), a four-entry
   // queue, and the back end (table read, fine and coarse arithmetic, result
   // register). The bin table is a 16384 x 16 memory with one write and two read
   // ports: a hit reads its own bin and the neighbor the dither sign selects in the
   // same cycle. Tables are not cleared after reset; load every entry before a hit
   // uses it. Every beat except request code 3 gives exactly one result beat.
   import tdccal_pkg::*;

   cfg_type        cfg;
   logic           q_push;
   work_type       q_push_data;
   logic           q_pop;
   logic           q_valid;
   work_type       q_head;
   queue_stat_type q_stat;

   tdccal_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tdccal_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_detector    (req_detector),
      .req_channel     (req_channel),
      .req_fine_time   (req_fine_time),
      .req_coarse_time (req_coarse_time),
      .req_dither      (req_dither),
      .req_load_value  (req_load_value),
      .q_full          (q_stat.full),
      .push            (q_push),
      .push_data       (q_push_data)
   );

   tdccal_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .head      (q_head),
      .stat      (q_stat)
   );

   tdccal_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_hit_detector (rsp_hit_detector),
      .rsp_hit_channel  (rsp_hit_channel),
      .rsp_time_value   (rsp_time_value),
      .rsp_clock_echo   (rsp_clock_echo)
   );

   // error and load results carry no time
   a_err_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_time_value == '0))
      else $error("non-hit result with nonzero time");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_LOAD_DONE))
      else $error("result status out of range");

   // queue fill moves by at most one entry per clock
   a_queue_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (q_stat.count == $past(q_stat.count))
                     || (q_stat.count == $past(q_stat.count) + QCNT_W'(1))
                     || (q_stat.count + QCNT_W'(1) == $past(q_stat.count)))
      else $error("queue count jumped");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

endmodule

// ===== tb/sv/tdccal_calib_checker.sv =====
// checker for the tdc calibrator: predicts every result beat and compares it with the block
module tdccal_calib_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic [tdccal_pkg::TYPE_W-1:0]           req_type,
   input  logic [tdccal_pkg::DET_W-1:0]            req_detector,
   input  logic [tdccal_pkg::CH_W-1:0]             req_channel,
   input  logic [tdccal_pkg::FINE_W-1:0]           req_fine_time,
   input  logic [tdccal_pkg::COARSE_W-1:0]         req_coarse_time,
   input  logic signed [tdccal_pkg::DITHER_W-1:0]  req_dither,
   input  logic signed [tdccal_pkg::LOAD_W-1:0]    req_load_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic [tdccal_pkg::STATUS_W-1:0]         rsp_status,
   input  logic [tdccal_pkg::DET_W-1:0]            rsp_hit_detector,
   input  logic [tdccal_pkg::CH_W-1:0]             rsp_hit_channel,
   input  logic signed [tdccal_pkg::TIME_W-1:0]    rsp_time_value,
   input  logic [tdccal_pkg::COARSE_W-1:0]         rsp_clock_echo,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic                                    csr_pready,
   input  logic [tdccal_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tdccal_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output int                                      fail_count,
   output int                                      pending
);
   import tdccal_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [DET_W-1:0]         detector;
      logic [CH_W-1:0]          channel;
      logic signed [TIME_W-1:0] time_value;
      logic [COARSE_W-1:0]      clock_echo;
   } calib_beat_type;

   logic [BINVAL_W-1:0]      bin_edge_mem [BIN_DEPTH];
   logic signed [LOAD_W-1:0] clock_offset_mem [SIGNALS];
   logic [DET_REG_W-1:0]     det_reg;
   logic [CH_REG_W-1:0]      ch_reg;
   logic [BIN_REG_W-1:0]     bin_reg;

   calib_beat_type calib_due [$];
   calib_beat_type due_beat;

   initial begin
      fail_count = 0;
      pending = 0;
      foreach (bin_edge_mem[i]) bin_edge_mem[i] = '0;
      foreach (clock_offset_mem[i]) clock_offset_mem[i] = '0;
   end

   function automatic int unsigned clamp(input int unsigned value, input int unsigned limit);
      return (value > limit) ? limit : value;
   endfunction

   // returns 1 when the beat produces a result, and updates the tables for loads
   function automatic bit predict_calibration(
      input  logic [TYPE_W-1:0]          kind,
      input  logic [DET_W-1:0]           det,
      input  logic [CH_W-1:0]            ch,
      input  logic [FINE_W-1:0]          fine,
      input  logic [COARSE_W-1:0]        coarse,
      input  logic signed [DITHER_W-1:0] dither,
      input  logic signed [LOAD_W-1:0]   load,
      output calib_beat_type             beat
   );
      int unsigned nd, nc, nb, sig, addr;
      longint par, nbr, diff, fine_v, coarse_v, total;
      nd = clamp(32'(det_reg), MAX_DETECTORS);
      nc = clamp(32'(ch_reg), MAX_CHANNELS);
      nb = clamp(32'(bin_reg), MAX_BINS);
      beat.status = ST_OK;
      beat.detector = det;
      beat.channel = ch;
      beat.time_value = '0;
      beat.clock_echo = coarse;
      if (kind == REQ_NONE) return 1'b0;
      if (det == 0 || det > nd) beat.status = ST_BAD_DET;
      else if (ch == 0 || ch > nc) beat.status = ST_BAD_CH;
      else if (kind != REQ_LOAD_OFFSET && fine >= nb) beat.status = ST_BAD_BIN;
      if (beat.status == ST_OK) begin
         sig = (det - 1) * nc + (ch - 1);
         addr = sig * nb + fine;
         case (kind)
            REQ_LOAD_BIN: begin
               bin_edge_mem[addr] = load[BINVAL_W-1:0];
               beat.status = ST_LOAD_DONE;
            end
            REQ_LOAD_OFFSET: begin
               clock_offset_mem[sig] = load;
               beat.status = ST_LOAD_DONE;
            end
            REQ_HIT: begin
               par = longint'(bin_edge_mem[addr]);
               // below the first bin counts as zero, past the last bin as the bin itself
               if (dither < 0) begin
                  nbr = (fine == 0) ? 0 : longint'(bin_edge_mem[addr - 1]);
                  diff = par - nbr;
               end else begin
                  nbr = (fine + 1 >= nb) ? par : longint'(bin_edge_mem[addr + 1]);
                  diff = nbr - par;
               end
               fine_v = par * 1024 + longint'(dither) * diff;
               coarse_v = 5 * (longint'(coarse) * 1024 - longint'(clock_offset_mem[sig])) * 1024;
               total = coarse_v - fine_v;
               beat.time_value = TIME_W'(total >>> 10);
            end
            default: ;
         endcase
      end
      return 1'b1;
   endfunction

   task automatic flag_field(input string field, input longint want, input longint got);
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         det_reg = DET_REG_W'(1);
         ch_reg = CH_REG_W'(1);
         bin_reg = BIN_REG_W'(MAX_BINS);
         calib_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_DETECTORS: det_reg = csr_pwdata[DET_REG_W-1:0];
               REG_CHANNELS:  ch_reg = csr_pwdata[CH_REG_W-1:0];
               REG_BINS:      bin_reg = csr_pwdata[BIN_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_calibration(req_type, req_detector, req_channel, req_fine_time,
                                    req_coarse_time, req_dither, req_load_value, due_beat))
               calib_due.push_back(due_beat);
         end
         if (rsp_valid && !rsp_stall) begin
            if (calib_due.size() == 0) begin
               $error("result beat with nothing expected: status %0d detector %0d",
                      rsp_status, rsp_hit_detector);
               fail_count++;
            end else begin
               due_beat = calib_due.pop_front();
               if (rsp_status !== due_beat.status)
                  flag_field("status", due_beat.status, rsp_status);
               if (rsp_hit_detector !== due_beat.detector)
                  flag_field("hit_detector", due_beat.detector, rsp_hit_detector);
               if (rsp_hit_channel !== due_beat.channel)
                  flag_field("hit_channel", due_beat.channel, rsp_hit_channel);
               if (rsp_time_value !== due_beat.time_value)
                  flag_field("time_value", due_beat.time_value, rsp_time_value);
               if (rsp_clock_echo !== due_beat.clock_echo)
                  flag_field("clock_echo", due_beat.clock_echo, rsp_clock_echo);
            end
         end
      end
      pending = calib_due.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: stimulus, settings and verdict for the tdc hit time calibrator
module tb;
   import tdccal_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int PHASES          = 8;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [TYPE_W-1:0]          req_type = REQ_NONE;
   logic [DET_W-1:0]           req_detector = '0;
   logic [CH_W-1:0]            req_channel = '0;
   logic [FINE_W-1:0]          req_fine_time = '0;
   logic [COARSE_W-1:0]        req_coarse_time = '0;
   logic signed [DITHER_W-1:0] req_dither = '0;
   logic signed [LOAD_W-1:0]   req_load_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [DET_W-1:0]           rsp_hit_detector;
   logic [CH_W-1:0]            rsp_hit_channel;
   logic signed [TIME_W-1:0]   rsp_time_value;
   logic [COARSE_W-1:0]        rsp_clock_echo;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_start = 1'b0;
   int quiet_cycles = 0;
   int phase_idx;
   int action_idx;

   int unsigned cur_nd = 1;
   int unsigned cur_nc = 1;
   int unsigned cur_nb = MAX_BINS;
   bit bin_loaded [BIN_DEPTH];
   bit offset_loaded [SIGNALS];

   int unsigned phase_det [PHASES]     = '{4, 4, 1, 7, 2, 3, 0, 4};
   int unsigned phase_ch [PHASES]      = '{4, 4, 1, 7, 3, 2, 0, 4};
   int unsigned phase_bins [PHASES]    = '{4, 1024, 2, 2047, 1, 5, 0, 16};
   int unsigned phase_actions [PHASES] = '{20, 45, 40, 45, 35, 40, 10, 45};
   int unsigned mode_send_idle [4]     = '{0, 84, 0, 24};
   int unsigned mode_recv_stall [4]    = '{0, 0, 84, 24};

   always #10 clock = ~clock;

   tdc_hit_time_calibrator_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_detector     (req_detector),
      .req_channel      (req_channel),
      .req_fine_time    (req_fine_time),
      .req_coarse_time  (req_coarse_time),
      .req_dither       (req_dither),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_hit_detector (rsp_hit_detector),
      .rsp_hit_channel  (rsp_hit_channel),
      .rsp_time_value   (rsp_time_value),
      .rsp_clock_echo   (rsp_clock_echo),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   tdccal_calib_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_detector     (req_detector),
      .req_channel      (req_channel),
      .req_fine_time    (req_fine_time),
      .req_coarse_time  (req_coarse_time),
      .req_dither       (req_dither),
      .req_load_value   (req_load_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_hit_detector (rsp_hit_detector),
      .rsp_hit_channel  (rsp_hit_channel),
      .rsp_time_value   (rsp_time_value),
      .rsp_clock_echo   (rsp_clock_echo),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // receiver: random stall, or one long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // would this beat touch the tables under the current setting
   function automatic bit is_clean(input logic [TYPE_W-1:0] kind, input logic [DET_W-1:0] det,
                                   input logic [CH_W-1:0] ch, input logic [FINE_W-1:0] fine);
      if (kind == REQ_NONE || det == 0 || det > cur_nd || ch == 0 || ch > cur_nc)
         return 1'b0;
      return (kind == REQ_LOAD_OFFSET) || (fine < cur_nb);
   endfunction

   function automatic int unsigned signal_of(input logic [DET_W-1:0] det,
                                             input logic [CH_W-1:0] ch);
      return (det - 1) * cur_nc + (ch - 1);
   endfunction

   function automatic logic [DET_W-1:0] pick_number(input int unsigned count);
      if (count > 0 && $urandom_range(99) < 85) return DET_W'($urandom_range(count, 1));
      return DET_W'($urandom_range(15));
   endfunction

   function automatic logic [FINE_W-1:0] pick_fine();
      if (cur_nb == 0) return FINE_W'($urandom_range(1023));
      case ($urandom_range(9))
         0, 1:    return '0;
         2, 3:    return FINE_W'(cur_nb - 1);
         4, 5, 6: return FINE_W'($urandom_range((cur_nb > 8) ? 7 : cur_nb - 1));
         7:       return FINE_W'($urandom_range(1023));
         default: return FINE_W'($urandom_range(cur_nb - 1));
      endcase
   endfunction

   function automatic logic signed [DITHER_W-1:0] pick_dither();
      case ($urandom_range(9))
         0:       return 10'h200;
         1:       return 10'h1FF;
         2:       return '0;
         3:       return '1;
         default: return DITHER_W'($urandom_range(1023));
      endcase
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic apply_setting(input int unsigned det_n, input int unsigned ch_n,
                                input int unsigned bin_n);
      write_register(REG_DETECTORS, det_n);
      write_register(REG_CHANNELS, ch_n);
      write_register(REG_BINS, bin_n);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_nd = ((det_n & 7) > MAX_DETECTORS) ? MAX_DETECTORS : (det_n & 7);
      cur_nc = ((ch_n & 7) > MAX_CHANNELS) ? MAX_CHANNELS : (ch_n & 7);
      cur_nb = ((bin_n & 2047) > MAX_BINS) ? MAX_BINS : (bin_n & 2047);
   endtask

   task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [DET_W-1:0] det,
                            input logic [CH_W-1:0] ch, input logic [FINE_W-1:0] fine,
                            input logic [COARSE_W-1:0] coarse,
                            input logic signed [DITHER_W-1:0] dither,
                            input logic signed [LOAD_W-1:0] load);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_detector <= det;
      req_channel <= ch;
      req_fine_time <= fine;
      req_coarse_time <= coarse;
      req_dither <= dither;
      req_load_value <= load;
      do @(posedge clock); while (req_stall);
      if (is_clean(kind, det, ch, fine)) begin
         if (kind == REQ_LOAD_BIN) bin_loaded[signal_of(det, ch) * cur_nb + fine] = 1'b1;
         else if (kind == REQ_LOAD_OFFSET) offset_loaded[signal_of(det, ch)] = 1'b1;
      end
   endtask

   // a hit preceded by whatever loads it needs so that no unwritten entry is read
   task automatic send_hit(input logic [DET_W-1:0] det, input logic [CH_W-1:0] ch,
                           input logic [FINE_W-1:0] fine,
                           input logic signed [DITHER_W-1:0] dither);
      int unsigned sig;
      int unsigned addr;
      if (is_clean(REQ_HIT, det, ch, fine)) begin
         sig = signal_of(det, ch);
         addr = sig * cur_nb + fine;
         if (!offset_loaded[sig])
            send_item(REQ_LOAD_OFFSET, det, ch, FINE_W'($urandom_range(1023)),
                      COARSE_W'($urandom_range(65535)), pick_dither(),
                      LOAD_W'($urandom_range(24'hFFFFFF)));
         if (!bin_loaded[addr])
            send_item(REQ_LOAD_BIN, det, ch, fine, COARSE_W'($urandom_range(65535)),
                      pick_dither(), LOAD_W'($urandom_range(24'hFFFFFF)));
         if (dither < 0 && fine > 0 && !bin_loaded[addr - 1])
            send_item(REQ_LOAD_BIN, det, ch, FINE_W'(fine - 1),
                      COARSE_W'($urandom_range(65535)), pick_dither(),
                      LOAD_W'($urandom_range(24'hFFFFFF)));
         if (dither >= 0 && fine + 1 < cur_nb && !bin_loaded[addr + 1])
            send_item(REQ_LOAD_BIN, det, ch, FINE_W'(fine + 1),
                      COARSE_W'($urandom_range(65535)), pick_dither(),
                      LOAD_W'($urandom_range(24'hFFFFFF)));
      end
      send_item(REQ_HIT, det, ch, fine, COARSE_W'($urandom_range(65535)), dither,
                LOAD_W'($urandom_range(24'hFFFFFF)));
   endtask

   task automatic random_action();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60)
         send_hit(pick_number(cur_nd), pick_number(cur_nc), pick_fine(), pick_dither());
      else if (roll < 75)
         send_item(REQ_LOAD_BIN, pick_number(cur_nd), pick_number(cur_nc), pick_fine(),
                   COARSE_W'($urandom_range(65535)), pick_dither(),
                   LOAD_W'($urandom_range(24'hFFFFFF)));
      else if (roll < 85)
         send_item(REQ_LOAD_OFFSET, pick_number(cur_nd), pick_number(cur_nc),
                   FINE_W'($urandom_range(1023)), COARSE_W'($urandom_range(65535)),
                   pick_dither(), LOAD_W'($urandom_range(24'hFFFFFF)));
      else if (roll < 93)
         send_hit(DET_W'($urandom_range(15)), CH_W'($urandom_range(15)),
                  FINE_W'($urandom_range(1023)), pick_dither());
      else
         send_item(REQ_NONE, DET_W'($urandom_range(15)), CH_W'($urandom_range(15)),
                   FINE_W'($urandom_range(1023)), COARSE_W'($urandom_range(65535)),
                   pick_dither(), LOAD_W'($urandom_range(24'hFFFFFF)));
   endtask

   // drop valid and wait until every outstanding result is back
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // runs under four detectors, four channels, four bins
   task automatic directed_items();
      send_item(REQ_LOAD_OFFSET, 1, 1, 1023, 0, 0, 24'h800000);
      send_item(REQ_LOAD_BIN, 1, 1, 0, 0, 0, 24'h7FFFFF);
      send_item(REQ_LOAD_BIN, 1, 1, 1, 0, 0, 24'h000000);
      send_item(REQ_LOAD_BIN, 1, 1, 2, 0, 0, 24'h123456);
      send_item(REQ_LOAD_BIN, 1, 1, 3, 0, 0, 24'h80ABCD);
      send_item(REQ_HIT, 1, 1, 0, 0, -512, 0);
      send_item(REQ_HIT, 1, 1, 3, 65535, 511, 0);
      send_item(REQ_HIT, 1, 1, 2, 1234, -1, 0);
      send_item(REQ_HIT, 1, 1, 1, 40000, 0, 0);
      send_item(REQ_HIT, 0, 1, 0, 7, 0, 0);
      send_item(REQ_HIT, 15, 15, 1023, 65535, 511, 24'hFFFFFF);
      send_item(REQ_HIT, 1, 0, 0, 8, 0, 0);
      send_item(REQ_HIT, 4, 15, 0, 9, 0, 0);
      send_item(REQ_HIT, 1, 1, 1023, 10, -512, 0);
      send_item(REQ_LOAD_BIN, 1, 1, 4, 11, 0, 24'h00FFFF);
      send_item(REQ_LOAD_OFFSET, 4, 4, 1023, 12, 0, 24'h7FFFFF);
      send_item(REQ_NONE, 1, 1, 0, 13, 0, 24'h555555);
      send_item(REQ_LOAD_OFFSET, 0, 2, 0, 14, 0, 24'h000001);
      send_hit(4, 4, 3, -512);
      send_hit(4, 4, 0, 511);
      send_hit(2, 3, 1, 0);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
         apply_setting(phase_det[phase_idx], phase_ch[phase_idx], phase_bins[phase_idx]);
         send_idle_pct = mode_send_idle[(phase_idx + 3) % 4];
         recv_stall_pct = mode_recv_stall[(phase_idx + 3) % 4];
         if (phase_idx == 0) directed_items();
         // long receiver hold-off while the sender keeps offering beats
         if (phase_idx == 1) hold_start = 1'b1;
         for (action_idx = 0; action_idx < phase_actions[phase_idx]; action_idx++) begin
            if (action_idx == phase_actions[phase_idx] / 2) quiesce();
            random_action();
         end
         quiesce();
      end
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
